[rtl/core/csv_pkg.sv]
// Shared types and constants for the color sample classify and vote block.
package csv_pkg;

   localparam int CHAN_W    = 16;
   localparam int SCALED_W  = 8;
   localparam int CNT_W     = 4;
   localparam int STEP_W    = 4;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 16;

   localparam int LANE_COUNT = 3;
   localparam int LANE_RED   = 0;
   localparam int LANE_GREEN = 1;
   localparam int LANE_BLUE  = 2;

   localparam logic [STEP_W-1:0]   QUOT_STEPS = STEP_W'(SCALED_W);
   localparam logic [SCALED_W-1:0] SCALED_MAX = '1;
   localparam logic [CNT_W-1:0]    CNT_MAX    = '1;

   typedef enum logic [1:0] {
      LANE_IDLE,
      LANE_CALC,
      LANE_DONE
   } lane_state_type;

   typedef struct packed {
      logic start;
      logic release_lane;
   } lane_ctl_type;

   typedef struct packed {
      logic idle;
      logic done;
   } lane_stat_type;

   typedef enum logic [2:0] {
      CLS_NONE  = 3'd0,
      CLS_WHITE = 3'd1,
      CLS_GREEN = 3'd2,
      CLS_RED   = 3'd3,
      CLS_BLUE  = 3'd4
   } class_type;

   typedef enum logic [2:0] {
      ROUTE_SPLIT = 3'd0,
      ROUTE_WHITE = 3'd1,
      ROUTE_RED   = 3'd2,
      ROUTE_GREEN = 3'd3,
      ROUTE_BLUE  = 3'd4
   } route_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_WHITE_CLEAR_MIN   = 3'd0,
      CSR_WHITE_RED_MIN     = 3'd1,
      CSR_WHITE_GREEN_MIN   = 3'd2,
      CSR_VALID_CLEAR_MIN   = 3'd3,
      CSR_BLUE_LEVEL_MIN    = 3'd4,
      CSR_VOTES_NEEDED      = 3'd5,
      CSR_SAMPLES_PER_BATCH = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic [CHAN_W-1:0]   white_clear_min;
      logic [SCALED_W-1:0] white_red_min;
      logic [SCALED_W-1:0] white_green_min;
      logic [CHAN_W-1:0]   valid_clear_min;
      logic [SCALED_W-1:0] blue_level_min;
      logic [CNT_W-1:0]    votes_needed;
      logic [CNT_W-1:0]    samples_per_batch;
   } cfg_type;

endpackage

[rtl/core/csv_lane.sv]
// One scaling lane: serial chan*255/clear with clamp to 255, or 0 when clear is zero.
module csv_lane (
   input  logic                          clock,
   input  logic                          reset,
   input  csv_pkg::lane_ctl_type         ctl,
   input  logic [csv_pkg::CHAN_W-1:0]    chan,
   input  logic [csv_pkg::CHAN_W-1:0]    clear,
   output csv_pkg::lane_stat_type        stat,
   output logic [csv_pkg::SCALED_W-1:0]  scaled
);

   localparam int DIVD_W = csv_pkg::CHAN_W + csv_pkg::SCALED_W;

   csv_pkg::lane_state_type state_ff, state_in;
   logic [csv_pkg::STEP_W-1:0]   step_ff, step_in;
   logic [csv_pkg::CHAN_W-1:0]   rem_ff, rem_in;
   logic [csv_pkg::SCALED_W-1:0] low_ff, low_in;
   logic [csv_pkg::CHAN_W-1:0]   divisor_ff, divisor_in;
   logic                         sat_ff, sat_in;

   logic [DIVD_W-1:0]   dividend;
   logic [csv_pkg::CHAN_W:0] trial;
   logic [csv_pkg::CHAN_W:0] diff;
   logic                fits;

   assign dividend = {chan, csv_pkg::SCALED_W'(0)} - {csv_pkg::SCALED_W'(0), chan};
   assign trial    = {rem_ff, low_ff[csv_pkg::SCALED_W-1]};
   assign diff     = trial - {1'b0, divisor_ff};
   assign fits     = trial >= {1'b0, divisor_ff};

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         csv_pkg::LANE_IDLE: begin
            if (ctl.start) begin
               state_in = csv_pkg::LANE_CALC;
            end
         end
         csv_pkg::LANE_CALC: begin
            if (step_ff == csv_pkg::QUOT_STEPS) begin
               state_in = csv_pkg::LANE_DONE;
            end
         end
         csv_pkg::LANE_DONE: begin
            if (ctl.release_lane) begin
               state_in = csv_pkg::LANE_IDLE;
            end
         end
         default: state_in = csv_pkg::LANE_IDLE;
      endcase
   end

   // datapath
   always_comb begin
      step_in    = step_ff;
      rem_in     = rem_ff;
      low_in     = low_ff;
      divisor_in = divisor_ff;
      sat_in     = sat_ff;
      if (state_ff == csv_pkg::LANE_IDLE && ctl.start) begin
         step_in    = '0;
         rem_in     = dividend[DIVD_W-1:csv_pkg::SCALED_W];
         low_in     = dividend[csv_pkg::SCALED_W-1:0];
         divisor_in = clear;
      end else if (state_ff == csv_pkg::LANE_CALC) begin
         step_in = step_ff + 1'b1;
         if (step_ff == '0) begin
            sat_in = (rem_ff >= divisor_ff) || (divisor_ff == '0);
         end else begin
            rem_in = fits ? diff[csv_pkg::CHAN_W-1:0] : trial[csv_pkg::CHAN_W-1:0];
            low_in = {low_ff[csv_pkg::SCALED_W-2:0], fits};
         end
      end
   end

   // outputs
   always_comb begin
      stat.idle = (state_ff == csv_pkg::LANE_IDLE);
      stat.done = (state_ff == csv_pkg::LANE_DONE);
      if (divisor_ff == '0) begin
         scaled = '0;
      end else if (sat_ff) begin
         scaled = csv_pkg::SCALED_MAX;
      end else begin
         scaled = low_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= csv_pkg::LANE_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff     <= rem_in;
      low_ff     <= low_in;
      divisor_ff <= divisor_in;
      sat_ff     <= sat_in;
   end

endmodule

[rtl/core/csv_vote.sv]
// Merge stage: classify the scaled sample, count votes and form the route decision.
module csv_vote (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          commit,
   input  csv_pkg::cfg_type              cfg,
   input  logic [csv_pkg::CHAN_W-1:0]    clear_raw,
   input  logic [csv_pkg::SCALED_W-1:0]  red,
   input  logic [csv_pkg::SCALED_W-1:0]  green,
   input  logic [csv_pkg::SCALED_W-1:0]  blue,
   output logic [csv_pkg::SCALED_W-1:0]  scaled_red,
   output logic [csv_pkg::SCALED_W-1:0]  scaled_green,
   output logic [csv_pkg::SCALED_W-1:0]  scaled_blue,
   output logic [2:0]                    sample_class,
   output logic                          decision_ready,
   output logic [2:0]                    route_action
);

   logic [csv_pkg::CNT_W-1:0] white_count_ff, white_count_in;
   logic [csv_pkg::CNT_W-1:0] red_count_ff, red_count_in;
   logic [csv_pkg::CNT_W-1:0] green_count_ff, green_count_in;
   logic [csv_pkg::CNT_W-1:0] blue_count_ff, blue_count_in;
   logic [csv_pkg::CNT_W-1:0] index_ff, index_in;

   logic [csv_pkg::SCALED_W-1:0] red_ff, green_ff, blue_ff;
   csv_pkg::class_type           class_ff, class_in;
   logic                         ready_ff, ready_in;
   csv_pkg::route_type           route_ff, route_in;

   logic [csv_pkg::CNT_W-1:0] white_bump, red_bump, green_bump, blue_bump;
   logic [csv_pkg::CNT_W-1:0] index_next;

   always_comb begin
      class_in = csv_pkg::CLS_NONE;
      priority if (clear_raw > cfg.white_clear_min && red > cfg.white_red_min
                   && green > cfg.white_green_min) begin
         class_in = csv_pkg::CLS_WHITE;
      end else if (clear_raw > cfg.valid_clear_min) begin
         priority if (green > red && green > blue) begin
            class_in = csv_pkg::CLS_GREEN;
         end else if (red > green && red > blue) begin
            class_in = csv_pkg::CLS_RED;
         end else if (blue > green && blue > cfg.blue_level_min) begin
            class_in = csv_pkg::CLS_BLUE;
         end else if (blue > red && blue > green) begin
            class_in = csv_pkg::CLS_BLUE;
         end else begin
            class_in = csv_pkg::CLS_NONE;
         end
      end else begin
         class_in = csv_pkg::CLS_NONE;
      end
   end

   // saturate at the counter maximum
   always_comb begin
      white_bump = white_count_ff;
      red_bump   = red_count_ff;
      green_bump = green_count_ff;
      blue_bump  = blue_count_ff;
      unique case (class_in)
         csv_pkg::CLS_WHITE: begin
            if (white_count_ff != csv_pkg::CNT_MAX) white_bump = white_count_ff + 1'b1;
         end
         csv_pkg::CLS_GREEN: begin
            if (green_count_ff != csv_pkg::CNT_MAX) green_bump = green_count_ff + 1'b1;
         end
         csv_pkg::CLS_RED: begin
            if (red_count_ff != csv_pkg::CNT_MAX) red_bump = red_count_ff + 1'b1;
         end
         csv_pkg::CLS_BLUE: begin
            if (blue_count_ff != csv_pkg::CNT_MAX) blue_bump = blue_count_ff + 1'b1;
         end
         default: begin
         end
      endcase
   end

   assign index_next = index_ff + 1'b1;

   always_comb begin
      white_count_in = white_count_ff;
      red_count_in   = red_count_ff;
      green_count_in = green_count_ff;
      blue_count_in  = blue_count_ff;
      index_in       = index_ff;
      ready_in       = 1'b0;
      route_in       = csv_pkg::ROUTE_SPLIT;
      if (commit) begin
         white_count_in = white_bump;
         red_count_in   = red_bump;
         green_count_in = green_bump;
         blue_count_in  = blue_bump;
         index_in       = index_next;
         if (index_next >= cfg.samples_per_batch) begin
            ready_in = 1'b1;
            priority if (white_bump >= cfg.votes_needed) begin
               route_in = csv_pkg::ROUTE_WHITE;
            end else if (red_bump >= cfg.votes_needed) begin
               route_in = csv_pkg::ROUTE_RED;
            end else if (green_bump >= cfg.votes_needed) begin
               route_in = csv_pkg::ROUTE_GREEN;
            end else if (blue_bump >= cfg.votes_needed) begin
               route_in = csv_pkg::ROUTE_BLUE;
            end else begin
               route_in = csv_pkg::ROUTE_SPLIT;
            end
            white_count_in = '0;
            red_count_in   = '0;
            green_count_in = '0;
            blue_count_in  = '0;
            index_in       = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         white_count_ff <= '0;
         red_count_ff   <= '0;
         green_count_ff <= '0;
         blue_count_ff  <= '0;
         index_ff       <= '0;
      end else begin
         white_count_ff <= white_count_in;
         red_count_ff   <= red_count_in;
         green_count_ff <= green_count_in;
         blue_count_ff  <= blue_count_in;
         index_ff       <= index_in;
      end
   end

   // hold the result beat until the next commit
   always_ff @(posedge clock) begin
      if (commit) begin
         red_ff   <= red;
         green_ff <= green;
         blue_ff  <= blue;
         class_ff <= class_in;
         ready_ff <= ready_in;
         route_ff <= route_in;
      end
   end

   assign scaled_red     = red_ff;
   assign scaled_green   = green_ff;
   assign scaled_blue    = blue_ff;
   assign sample_class   = class_ff;
   assign decision_ready = ready_ff;
   assign route_action   = route_ff;

endmodule

[rtl/core/color_sample_classify_vote.sv]
// Top level of the color sample classify and vote block.
//
//   channel | direction | handshake          | beat
//   req     | in        | req_valid/req_stall | clear, red, green, blue raw counts
//   rsp     | out       | rsp_valid/rsp_stall | scaled colors, class, decision, route
//   csr     | in        | csr_write           | register index and data
//
// Three scaling lanes each run a serial divider (one clamp check, then one
// quotient bit per cycle); once all lanes finish and rsp is free, the beat is
// registered in the vote stage and rsp_valid rises, and a new item is taken
// only after the lanes hand off and return to idle.
// Reset is synchronous and clears the lanes, vote counters and rsp_valid.
// A stalled rsp holds its beat; the lanes then hold their result and req stalls.
module color_sample_classify_vote (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [csv_pkg::CHAN_W-1:0]     req_clear_raw,
   input  logic [csv_pkg::CHAN_W-1:0]     req_red_raw,
   input  logic [csv_pkg::CHAN_W-1:0]     req_green_raw,
   input  logic [csv_pkg::CHAN_W-1:0]     req_blue_raw,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [csv_pkg::SCALED_W-1:0]   rsp_scaled_red,
   output logic [csv_pkg::SCALED_W-1:0]   rsp_scaled_green,
   output logic [csv_pkg::SCALED_W-1:0]   rsp_scaled_blue,
   output logic [2:0]                     rsp_sample_class,
   output logic                           rsp_decision_ready,
   output logic [2:0]                     rsp_route_action,
   input  logic                           csr_write,
   input  logic [csv_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [csv_pkg::CSR_DATA_W-1:0] csr_data
);

   csv_pkg::cfg_type cfg_ff, cfg_in;
   logic [csv_pkg::CHAN_W-1:0] clear_ff;
   logic rsp_valid_ff, rsp_valid_in;

   csv_pkg::lane_ctl_type  lane_ctl;
   csv_pkg::lane_stat_type lane_stat [csv_pkg::LANE_COUNT];
   logic [csv_pkg::CHAN_W-1:0]   lane_chan   [csv_pkg::LANE_COUNT];
   logic [csv_pkg::SCALED_W-1:0] lane_scaled [csv_pkg::LANE_COUNT];
   logic [csv_pkg::LANE_COUNT-1:0] idle_bits, done_bits;

   logic accept, lanes_idle, lanes_done, out_free, commit;

   assign lane_chan[csv_pkg::LANE_RED]   = req_red_raw;
   assign lane_chan[csv_pkg::LANE_GREEN] = req_green_raw;
   assign lane_chan[csv_pkg::LANE_BLUE]  = req_blue_raw;

   for (genvar i = 0; i < csv_pkg::LANE_COUNT; i++) begin : g_lane
      csv_lane u_lane (
         .clock  (clock),
         .reset  (reset),
         .ctl    (lane_ctl),
         .chan   (lane_chan[i]),
         .clear  (req_clear_raw),
         .stat   (lane_stat[i]),
         .scaled (lane_scaled[i])
      );
      assign idle_bits[i] = lane_stat[i].idle;
      assign done_bits[i] = lane_stat[i].done;
   end

   assign lanes_idle = &idle_bits;
   assign lanes_done = &done_bits;
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign commit     = lanes_done && out_free;
   assign req_stall  = !lanes_idle;
   assign accept     = req_valid && lanes_idle;

   assign lane_ctl.start        = accept;
   assign lane_ctl.release_lane = commit;

   csv_vote u_vote (
      .clock          (clock),
      .reset          (reset),
      .commit         (commit),
      .cfg            (cfg_ff),
      .clear_raw      (clear_ff),
      .red            (lane_scaled[csv_pkg::LANE_RED]),
      .green          (lane_scaled[csv_pkg::LANE_GREEN]),
      .blue           (lane_scaled[csv_pkg::LANE_BLUE]),
      .scaled_red     (rsp_scaled_red),
      .scaled_green   (rsp_scaled_green),
      .scaled_blue    (rsp_scaled_blue),
      .sample_class   (rsp_sample_class),
      .decision_ready (rsp_decision_ready),
      .route_action   (rsp_route_action)
   );

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_index)
            csv_pkg::CSR_WHITE_CLEAR_MIN:   cfg_in.white_clear_min = csr_data;
            csv_pkg::CSR_WHITE_RED_MIN:
               cfg_in.white_red_min = csr_data[csv_pkg::SCALED_W-1:0];
            csv_pkg::CSR_WHITE_GREEN_MIN:
               cfg_in.white_green_min = csr_data[csv_pkg::SCALED_W-1:0];
            csv_pkg::CSR_VALID_CLEAR_MIN:   cfg_in.valid_clear_min = csr_data;
            csv_pkg::CSR_BLUE_LEVEL_MIN:
               cfg_in.blue_level_min = csr_data[csv_pkg::SCALED_W-1:0];
            csv_pkg::CSR_VOTES_NEEDED:
               cfg_in.votes_needed = csr_data[csv_pkg::CNT_W-1:0];
            csv_pkg::CSR_SAMPLES_PER_BATCH:
               cfg_in.samples_per_batch = csr_data[csv_pkg::CNT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (commit) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.white_clear_min   <= 16'd200;
         cfg_ff.white_red_min     <= 8'd210;
         cfg_ff.white_green_min   <= 8'd180;
         cfg_ff.valid_clear_min   <= 16'd15;
         cfg_ff.blue_level_min    <= 8'd140;
         cfg_ff.votes_needed      <= 4'd3;
         cfg_ff.samples_per_batch <= 4'd5;
         rsp_valid_ff             <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         clear_ff <= req_clear_raw;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

[sim/color_sample_classify_vote_tb.sv]
// Self-checking testbench for the color sample classify and vote block.

typedef struct packed {
   logic [csv_pkg::CHAN_W-1:0] clear_raw;
   logic [csv_pkg::CHAN_W-1:0] red_raw;
   logic [csv_pkg::CHAN_W-1:0] green_raw;
   logic [csv_pkg::CHAN_W-1:0] blue_raw;
} sample_type;

typedef struct packed {
   logic [csv_pkg::SCALED_W-1:0] scaled_red;
   logic [csv_pkg::SCALED_W-1:0] scaled_green;
   logic [csv_pkg::SCALED_W-1:0] scaled_blue;
   csv_pkg::class_type           sample_class;
   logic                         decision_ready;
   csv_pkg::route_type           route_action;
} verdict_type;

class vote_tracker;
   csv_pkg::cfg_type           cfg;
   logic [csv_pkg::CNT_W-1:0]  white_tally;
   logic [csv_pkg::CNT_W-1:0]  red_tally;
   logic [csv_pkg::CNT_W-1:0]  green_tally;
   logic [csv_pkg::CNT_W-1:0]  blue_tally;
   logic [csv_pkg::STEP_W-1:0] batch_pos;
   verdict_type                awaited_verdicts[$];
   int                         mismatches;

   function new();
      cfg.white_clear_min   = 16'd200;
      cfg.white_red_min     = 8'd210;
      cfg.white_green_min   = 8'd180;
      cfg.valid_clear_min   = 16'd15;
      cfg.blue_level_min    = 8'd140;
      cfg.votes_needed      = 4'd3;
      cfg.samples_per_batch = 4'd5;
      white_tally = '0;
      red_tally   = '0;
      green_tally = '0;
      blue_tally  = '0;
      batch_pos   = '0;
      mismatches  = 0;
   endfunction

   function void write_reg(csv_pkg::csr_index_type idx,
                           logic [csv_pkg::CSR_DATA_W-1:0] val);
      case (idx)
         csv_pkg::CSR_WHITE_CLEAR_MIN:   cfg.white_clear_min = val;
         csv_pkg::CSR_WHITE_RED_MIN:     cfg.white_red_min = val[csv_pkg::SCALED_W-1:0];
         csv_pkg::CSR_WHITE_GREEN_MIN:   cfg.white_green_min = val[csv_pkg::SCALED_W-1:0];
         csv_pkg::CSR_VALID_CLEAR_MIN:   cfg.valid_clear_min = val;
         csv_pkg::CSR_BLUE_LEVEL_MIN:    cfg.blue_level_min = val[csv_pkg::SCALED_W-1:0];
         csv_pkg::CSR_VOTES_NEEDED:      cfg.votes_needed = val[csv_pkg::CNT_W-1:0];
         csv_pkg::CSR_SAMPLES_PER_BATCH: cfg.samples_per_batch = val[csv_pkg::CNT_W-1:0];
         default: ;
      endcase
   endfunction

   function logic [csv_pkg::SCALED_W-1:0] scale_to_clear(logic [csv_pkg::CHAN_W-1:0] chan,
                                                         logic [csv_pkg::CHAN_W-1:0] clear);
      int unsigned num;
      int unsigned den;
      int unsigned q;
      num = chan;
      den = clear;
      if (den == 0) return '0;
      q = (num * 255) / den;
      return (q > 255) ? csv_pkg::SCALED_MAX : q[csv_pkg::SCALED_W-1:0];
   endfunction

   function verdict_type classify_and_vote(sample_type s);
      verdict_type v;
      v.scaled_red     = scale_to_clear(s.red_raw, s.clear_raw);
      v.scaled_green   = scale_to_clear(s.green_raw, s.clear_raw);
      v.scaled_blue    = scale_to_clear(s.blue_raw, s.clear_raw);
      v.sample_class   = csv_pkg::CLS_NONE;
      v.decision_ready = 1'b0;
      v.route_action   = csv_pkg::ROUTE_SPLIT;
      if (s.clear_raw > cfg.white_clear_min && v.scaled_red > cfg.white_red_min &&
          v.scaled_green > cfg.white_green_min) begin
         v.sample_class = csv_pkg::CLS_WHITE;
      end else if (s.clear_raw > cfg.valid_clear_min) begin
         if (v.scaled_green > v.scaled_red && v.scaled_green > v.scaled_blue)
            v.sample_class = csv_pkg::CLS_GREEN;
         else if (v.scaled_red > v.scaled_green && v.scaled_red > v.scaled_blue)
            v.sample_class = csv_pkg::CLS_RED;
         else if (v.scaled_blue > v.scaled_green && v.scaled_blue > cfg.blue_level_min)
            v.sample_class = csv_pkg::CLS_BLUE;
         else if (v.scaled_blue > v.scaled_red && v.scaled_blue > v.scaled_green)
            v.sample_class = csv_pkg::CLS_BLUE;
      end
      // saturate each vote count
      case (v.sample_class)
         csv_pkg::CLS_WHITE:
            if (white_tally != csv_pkg::CNT_MAX) white_tally = white_tally + 1'b1;
         csv_pkg::CLS_GREEN:
            if (green_tally != csv_pkg::CNT_MAX) green_tally = green_tally + 1'b1;
         csv_pkg::CLS_RED:
            if (red_tally != csv_pkg::CNT_MAX) red_tally = red_tally + 1'b1;
         csv_pkg::CLS_BLUE:
            if (blue_tally != csv_pkg::CNT_MAX) blue_tally = blue_tally + 1'b1;
         default: ;
      endcase
      batch_pos = batch_pos + 1'b1;
      if (batch_pos >= cfg.samples_per_batch) begin
         v.decision_ready = 1'b1;
         if (white_tally >= cfg.votes_needed)
            v.route_action = csv_pkg::ROUTE_WHITE;
         else if (red_tally >= cfg.votes_needed)
            v.route_action = csv_pkg::ROUTE_RED;
         else if (green_tally >= cfg.votes_needed)
            v.route_action = csv_pkg::ROUTE_GREEN;
         else if (blue_tally >= cfg.votes_needed)
            v.route_action = csv_pkg::ROUTE_BLUE;
         white_tally = '0;
         red_tally   = '0;
         green_tally = '0;
         blue_tally  = '0;
         batch_pos   = '0;
      end
      return v;
   endfunction

   function void take_sample(sample_type s);
      awaited_verdicts.push_back(classify_and_vote(s));
   endfunction

   function void match_verdict(verdict_type got);
      verdict_type want;
      if (awaited_verdicts.size() == 0) begin
         mismatches++;
         if (mismatches <= 10)
            $display("unexpected rsp beat: rgb=%0d/%0d/%0d class=%0d ready=%0b route=%0d",
                     got.scaled_red, got.scaled_green, got.scaled_blue,
                     got.sample_class, got.decision_ready, got.route_action);
         return;
      end
      want = awaited_verdicts.pop_front();
      if (got.scaled_red !== want.scaled_red || got.scaled_green !== want.scaled_green ||
          got.scaled_blue !== want.scaled_blue || got.sample_class !== want.sample_class ||
          got.decision_ready !== want.decision_ready ||
          got.route_action !== want.route_action) begin
         mismatches++;
         if (mismatches <= 10)
            $display({"rsp mismatch: exp rgb=%0d/%0d/%0d class=%0d ready=%0b route=%0d",
                      " got rgb=%0d/%0d/%0d class=%0d ready=%0b route=%0d"},
                     want.scaled_red, want.scaled_green, want.scaled_blue,
                     want.sample_class, want.decision_ready, want.route_action,
                     got.scaled_red, got.scaled_green, got.scaled_blue,
                     got.sample_class, got.decision_ready, got.route_action);
      end
   endfunction

   function int pending();
      return awaited_verdicts.size();
   endfunction
endclass

module color_sample_classify_vote_tb;
   localparam int QUIET_LIMIT   = 2000;
   localparam int TAIL_CYCLES   = 20;
   localparam int PHASES        = 10;
   localparam int PHASE_SAMPLES = 103;

   typedef enum {TONE_WHITE, TONE_GREEN, TONE_RED, TONE_BLUE, TONE_NOISE, TONE_DARK} tone_type;

   logic                           clock;
   logic                           reset = 1'b1;
   logic                           req_valid = 1'b0;
   logic                           req_stall;
   logic [csv_pkg::CHAN_W-1:0]     req_clear_raw = '0;
   logic [csv_pkg::CHAN_W-1:0]     req_red_raw = '0;
   logic [csv_pkg::CHAN_W-1:0]     req_green_raw = '0;
   logic [csv_pkg::CHAN_W-1:0]     req_blue_raw = '0;
   logic                           rsp_valid;
   logic                           rsp_stall = 1'b0;
   logic [csv_pkg::SCALED_W-1:0]   rsp_scaled_red;
   logic [csv_pkg::SCALED_W-1:0]   rsp_scaled_green;
   logic [csv_pkg::SCALED_W-1:0]   rsp_scaled_blue;
   logic [2:0]                     rsp_sample_class;
   logic                           rsp_decision_ready;
   logic [2:0]                     rsp_route_action;
   logic                           csr_write = 1'b0;
   csv_pkg::csr_index_type         csr_index = csv_pkg::CSR_WHITE_CLEAR_MIN;
   logic [csv_pkg::CSR_DATA_W-1:0] csr_data = '0;

   int          send_gap_pct = 0;
   int          rsp_stall_pct = 0;
   int          quiet_cycles = 0;
   vote_tracker tracker;

   color_sample_classify_vote dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_clear_raw      (req_clear_raw),
      .req_red_raw        (req_red_raw),
      .req_green_raw      (req_green_raw),
      .req_blue_raw       (req_blue_raw),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_scaled_red     (rsp_scaled_red),
      .rsp_scaled_green   (rsp_scaled_green),
      .rsp_scaled_blue    (rsp_scaled_blue),
      .rsp_sample_class   (rsp_sample_class),
      .rsp_decision_ready (rsp_decision_ready),
      .rsp_route_action   (rsp_route_action),
      .csr_write          (csr_write),
      .csr_index          (csr_index),
      .csr_data           (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         tracker.match_verdict('{rsp_scaled_red, rsp_scaled_green, rsp_scaled_blue,
                                 csv_pkg::class_type'(rsp_sample_class), rsp_decision_ready,
                                 csv_pkg::route_type'(rsp_route_action)});
      rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("color_sample_classify_vote_tb NOT OK");
         $finish;
      end
   end

   task automatic send_sample(sample_type s);
      while ($urandom_range(99) < send_gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_clear_raw <= s.clear_raw;
      req_red_raw   <= s.red_raw;
      req_green_raw <= s.green_raw;
      req_blue_raw  <= s.blue_raw;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      tracker.take_sample(s);
   endtask

   task automatic send_raw(int unsigned c, int unsigned r, int unsigned g, int unsigned b);
      send_sample('{c[csv_pkg::CHAN_W-1:0], r[csv_pkg::CHAN_W-1:0],
                    g[csv_pkg::CHAN_W-1:0], b[csv_pkg::CHAN_W-1:0]});
   endtask

   task automatic put_reg(csv_pkg::csr_index_type idx, logic [csv_pkg::CSR_DATA_W-1:0] val);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      tracker.write_reg(idx, val);
   endtask

   task automatic program_cfg(csv_pkg::cfg_type c);
      put_reg(csv_pkg::CSR_WHITE_CLEAR_MIN, c.white_clear_min);
      put_reg(csv_pkg::CSR_WHITE_RED_MIN, csv_pkg::CSR_DATA_W'(c.white_red_min));
      put_reg(csv_pkg::CSR_WHITE_GREEN_MIN, csv_pkg::CSR_DATA_W'(c.white_green_min));
      put_reg(csv_pkg::CSR_VALID_CLEAR_MIN, c.valid_clear_min);
      put_reg(csv_pkg::CSR_BLUE_LEVEL_MIN, csv_pkg::CSR_DATA_W'(c.blue_level_min));
      put_reg(csv_pkg::CSR_VOTES_NEEDED, csv_pkg::CSR_DATA_W'(c.votes_needed));
      put_reg(csv_pkg::CSR_SAMPLES_PER_BATCH, csv_pkg::CSR_DATA_W'(c.samples_per_batch));
      csr_write <= 1'b0;
   endtask

   task automatic drain();
      while (tracker.pending() != 0) @(posedge clock);
   endtask

   function automatic sample_type make_sample(tone_type tone);
      int unsigned c;
      int unsigned lead;
      int unsigned a;
      int unsigned b;
      sample_type s;
      c    = $urandom_range(65535, 16);
      lead = c * $urandom_range(100, 20) / 100;
      a    = lead * $urandom_range(95, 0) / 100;
      b    = lead * $urandom_range(95, 0) / 100;
      case (tone)
         TONE_WHITE: begin
            c = $urandom_range(65535, 250);
            s = '{c[15:0], 16'(c * $urandom_range(100, 80) / 100),
                  16'(c * $urandom_range(100, 70) / 100), 16'(c * $urandom_range(100) / 100)};
         end
         TONE_GREEN: s = '{c[15:0], a[15:0], lead[15:0], b[15:0]};
         TONE_RED:   s = '{c[15:0], lead[15:0], a[15:0], b[15:0]};
         TONE_BLUE:  s = '{c[15:0], a[15:0], b[15:0], lead[15:0]};
         TONE_DARK:  s = '{16'($urandom_range(40)), 16'($urandom_range(40)),
                           16'($urandom_range(40)), 16'($urandom_range(40))};
         default:    s = '{16'($urandom_range(65535)), 16'($urandom_range(65535)),
                           16'($urandom_range(65535)), 16'($urandom_range(65535))};
      endcase
      return s;
   endfunction

   function automatic csv_pkg::cfg_type phase_setting(int p);
      csv_pkg::cfg_type c;
      c.white_clear_min   = 16'($urandom_range(3000));
      c.white_red_min     = 8'($urandom_range(255, 100));
      c.white_green_min   = 8'($urandom_range(255, 80));
      c.valid_clear_min   = 16'($urandom_range(200));
      c.blue_level_min    = 8'($urandom_range(255));
      c.samples_per_batch = 4'($urandom_range(15, 1));
      c.votes_needed      = 4'($urandom_range(c.samples_per_batch, 1));
      case (p)
         2: c = '0;
         3: c = '1;
         5: c = '{16'd100, 8'd200, 8'd150, 16'd10, 8'd128, 4'd1, 4'd1};
         7: c = '{16'd200, 8'd210, 8'd180, 16'd15, 8'd140, 4'd15, 4'd15};
         default: ;
      endcase
      return c;
   endfunction

   initial begin
      tone_type tone;
      int       run_left;
      tracker = new();
      tone = TONE_WHITE;
      run_left = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      send_raw(0, 0, 0, 0);
      send_raw(0, 65535, 65535, 65535);
      send_raw(65535, 65535, 65535, 65535);
      send_raw(1, 65535, 0, 1);
      send_raw(1000, 900, 800, 100);
      send_raw(200, 900, 800, 100);
      send_raw(1000, 200, 600, 100);
      send_raw(1000, 600, 200, 100);
      send_raw(1000, 700, 300, 700);
      send_raw(1000, 100, 200, 500);
      send_raw(1000, 400, 400, 400);
      send_raw(15, 0, 15, 0);
      send_raw(16, 0, 16, 0);
      send_raw(65535, 0, 0, 0);
      send_raw(1000, 500, 500, 100);
      send_raw(1000, 950, 900, 10);
      send_raw(40000, 39000, 38000, 20000);
      send_raw(300, 290, 280, 0);
      send_raw(1000, 600, 100, 100);
      send_raw(1000, 800, 100, 50);

      for (int p = 0; p < PHASES; p++) begin
         req_valid <= 1'b0;
         drain();
         if (p != 0) program_cfg(phase_setting(p));
         case (p % 4)
            0: begin send_gap_pct = 0;  rsp_stall_pct = 0;  end
            1: begin send_gap_pct = 61; rsp_stall_pct = 0;  end
            2: begin send_gap_pct = 0;  rsp_stall_pct = 61; end
            default: begin send_gap_pct = 21; rsp_stall_pct = 21; end
         endcase
         for (int i = 0; i < PHASE_SAMPLES; i++) begin
            if (run_left == 0) begin
               tone = tone_type'($urandom_range(5));
               run_left = $urandom_range(20, 1);
            end
            run_left--;
            // hold one tone across most samples of a run so batches build up real votes
            if ($urandom_range(7) == 0)
               send_sample(make_sample(tone_type'($urandom_range(5))));
            else
               send_sample(make_sample(tone));
         end
      end

      req_valid <= 1'b0;
      drain();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (tracker.mismatches == 0 && tracker.pending() == 0)
         $display("color_sample_classify_vote_tb OK");
      else
         $display("color_sample_classify_vote_tb NOT OK");
      $finish;
   end
endmodule

[filelist.f]
rtl/core/csv_pkg.sv
rtl/core/csv_lane.sv
rtl/core/csv_vote.sv
rtl/core/color_sample_classify_vote.sv
sim/color_sample_classify_vote_tb.sv
